/* hw/rtl/fvl_pkg.sv */
// ----------------------------------------------------------------------------
// fvl_pkg
// types, codes and constants shared by the four-valued logic vector alu
// ----------------------------------------------------------------------------
package fvl_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned ELEMS      = 16;
   localparam int unsigned KIND_W     = 4;
   localparam int unsigned TAIL_W     = 5;
   localparam int unsigned COUNT_W    = 11;
   localparam int unsigned POP_W      = 5;

   localparam int unsigned MAX_ELEMENTS = 1024;
   localparam logic [COUNT_W-1:0] COUNT_CAP =
      (MAX_ELEMENTS > 2047) ? COUNT_W'(2047) : COUNT_W'(MAX_ELEMENTS);

   localparam logic [WORD_W-1:0] LOW_BITS  = 32'h5555_5555;
   localparam logic [WORD_W-1:0] HIGH_BITS = 32'hAAAA_AAAA;
   localparam logic [WORD_W-1:0] ALL_BITS  = 32'hFFFF_FFFF;
   localparam logic [WORD_W-1:0] PAIR_MASK = 32'h3333_3333;
   localparam logic [WORD_W-1:0] NIB_MASK  = 32'h0F0F_0F0F;

   typedef enum logic [KIND_W-1:0] {
      KIND_AND        = 4'd0,
      KIND_OR         = 4'd1,
      KIND_NOT        = 4'd2,
      KIND_UNION      = 4'd3,
      KIND_INTERSECT  = 4'd4,
      KIND_COMPLEMENT = 4'd5,
      KIND_DIFFCOUNT  = 4'd6,
      KIND_SUBSET     = 4'd7,
      KIND_EQUAL      = 4'd8,
      KIND_CONFLICT   = 4'd9,
      KIND_UPCONF     = 4'd10,
      KIND_DOWNCONF   = 4'd11,
      KIND_ALLNULL    = 4'd12,
      KIND_ALLZERO    = 4'd13,
      KIND_ALLONE     = 4'd14,
      KIND_ALLX       = 4'd15
   } kind_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              is_pred;
      logic              term;
      logic              is_count;
      logic [POP_W-1:0]  pop;
   } unit_out_type;

endpackage

/* hw/rtl/fvl_word_unit.sv */
// ----------------------------------------------------------------------------
// fvl_word_unit
// per-word logic: word operations, predicate term and differing-element count
// ----------------------------------------------------------------------------
module fvl_word_unit import fvl_pkg::*; (
   input  kind_type           kind,
   input  logic [WORD_W-1:0]  word_a,
   input  logic [WORD_W-1:0]  word_b,
   input  logic               last_word,
   input  logic [TAIL_W-1:0]  tail_count,
   output unit_out_type       res
);

   logic [WORD_W-1:0] full;
   logic [WORD_W-1:0] lm;
   logic [WORD_W-1:0] diff;
   logic [WORD_W-1:0] nand_ab;
   logic [WORD_W-1:0] p1;
   logic [WORD_W-1:0] p2;
   logic [5:0]        shamt;

   always_comb begin
      shamt = 6'(6'd32 - {tail_count, 1'b0});
      if (!last_word || tail_count == '0 || tail_count >= TAIL_W'(ELEMS)) begin
         full = ALL_BITS;
      end else begin
         full = ALL_BITS << shamt;
      end
      lm = full & LOW_BITS;
   end

   // popcount of differing element flags
   always_comb begin
      diff = word_a ^ word_b;
      diff = (diff | (diff >> 1)) & lm;
      p1   = (diff & PAIR_MASK) + ((diff >> 2) & PAIR_MASK);
      p2   = (p1 & NIB_MASK) + ((p1 >> 4) & NIB_MASK);
      nand_ab = ~(word_a & word_b);
   end

   always_comb begin
      res          = '0;
      res.is_count = (kind == KIND_DIFFCOUNT);
      res.pop      = POP_W'(p2[7:0] + p2[15:8] + p2[23:16] + p2[31:24]);
      res.is_pred  = 1'b0;
      case (kind)
         KIND_AND: begin
            res.word = (word_a & word_b & HIGH_BITS) |
                       (((word_a & (word_b >> 1)) | (word_a & word_b) |
                         (word_b & (word_a >> 1))) & LOW_BITS);
         end
         KIND_OR: begin
            res.word = (((word_a & (word_b << 1)) | (word_a & word_b) |
                         (word_b & (word_a << 1))) & HIGH_BITS) |
                       (word_a & word_b & LOW_BITS);
         end
         KIND_NOT: begin
            res.word = ((word_a << 1) & HIGH_BITS) | ((word_a >> 1) & LOW_BITS);
         end
         KIND_UNION:      res.word = word_a | word_b;
         KIND_INTERSECT:  res.word = word_a & word_b;
         KIND_COMPLEMENT: res.word = (~word_a) & full;
         KIND_DIFFCOUNT:  res.word = '0;
         KIND_SUBSET: begin
            res.is_pred = 1'b1;
            res.term    = ((word_a & word_b & full) == (word_b & full));
         end
         KIND_EQUAL: begin
            res.is_pred = 1'b1;
            res.term    = ((word_a & full) == (word_b & full));
         end
         KIND_CONFLICT: begin
            res.is_pred = 1'b1;
            res.term    = (((nand_ab >> 1) & nand_ab & lm) == '0);
         end
         KIND_UPCONF: begin
            res.is_pred = 1'b1;
            res.term    = ((~(word_a >> 1) & word_a & (word_b >> 1) & ~word_b & lm)
                           == '0);
         end
         KIND_DOWNCONF: begin
            res.is_pred = 1'b1;
            res.term    = (((word_a >> 1) & ~word_a & ~(word_b >> 1) & word_b & lm)
                           == '0);
         end
         KIND_ALLNULL: begin
            res.is_pred = 1'b1;
            res.term    = ((((word_a >> 1) | word_a) & lm) == '0);
         end
         KIND_ALLZERO: begin
            res.is_pred = 1'b1;
            res.term    = ((((word_a >> 1) | ~word_a) & lm) == '0);
         end
         KIND_ALLONE: begin
            res.is_pred = 1'b1;
            res.term    = ((((~word_a) >> 1) | word_a) & lm) == '0;
         end
         default: begin
            res.is_pred = 1'b1;
            res.term    = ((((~word_a) >> 1) | ~word_a) & lm) == '0;
         end
      endcase
   end

endmodule

/* hw/rtl/four_valued_logic_vector_alu_top.sv */
// ----------------------------------------------------------------------------
// four_valued_logic_vector_alu_top
// from req accept to rsp valid an item passes the input register, then the result register
// throughput: one item per cycle while rsp_stall is low, the word logic is a single combinational pass
// a stalled result lets one more item into the input register, then req stalls
// reset: synchronous; empties both registers, predicate to one, count to zero
// ----------------------------------------------------------------------------
module four_valued_logic_vector_alu_top import fvl_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [WORD_W-1:0]   req_word_a,
   input  logic [WORD_W-1:0]   req_word_b,
   input  logic                req_last_word,
   input  logic [TAIL_W-1:0]   req_tail_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [WORD_W-1:0]   rsp_result_word,
   output logic                rsp_predicate,
   output logic [COUNT_W-1:0]  rsp_diff_total,
   output logic                rsp_last_result
);

   logic               in_valid_ff, in_valid_in;
   kind_type           in_kind_ff, in_kind_in;
   logic [WORD_W-1:0]  in_a_ff, in_a_in;
   logic [WORD_W-1:0]  in_b_ff, in_b_in;
   logic               in_last_ff, in_last_in;
   logic [TAIL_W-1:0]  in_tail_ff, in_tail_in;

   logic               out_valid_ff, out_valid_in;
   logic [WORD_W-1:0]  out_word_ff, out_word_in;
   logic               out_pred_ff, out_pred_in;
   logic [COUNT_W-1:0] out_total_ff, out_total_in;
   logic               out_last_ff, out_last_in;

   logic               pred_acc_ff, pred_acc_in;
   logic [COUNT_W-1:0] count_acc_ff, count_acc_in;

   unit_out_type       unit_res;
   logic               out_free;
   logic               fire;
   logic               take;
   logic               new_pred;
   logic [COUNT_W:0]   sum;
   logic [COUNT_W-1:0] new_count;

   fvl_word_unit u_word_unit (
      .kind       (in_kind_ff),
      .word_a     (in_a_ff),
      .word_b     (in_b_ff),
      .last_word  (in_last_ff),
      .tail_count (in_tail_ff),
      .res        (unit_res)
   );

   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      fire      = in_valid_ff && out_free;
      req_stall = in_valid_ff && !out_free;
      take      = req_valid && !req_stall;

      in_valid_in = take || (in_valid_ff && !fire);
      in_kind_in  = take ? kind_type'(req_kind) : in_kind_ff;
      in_a_in     = take ? req_word_a : in_a_ff;
      in_b_in     = take ? req_word_b : in_b_ff;
      in_last_in  = take ? req_last_word : in_last_ff;
      in_tail_in  = take ? req_tail_count : in_tail_ff;

      new_pred  = pred_acc_ff & unit_res.term;
      sum       = {1'b0, count_acc_ff} + (COUNT_W + 1)'(unit_res.pop);
      new_count = (sum > {1'b0, COUNT_CAP}) ? COUNT_CAP : sum[COUNT_W-1:0];

      out_valid_in = fire || (out_valid_ff && !out_free);
      out_word_in  = fire ? unit_res.word : out_word_ff;
      out_pred_in  = fire ? (unit_res.is_pred & new_pred) : out_pred_ff;
      out_total_in = fire ? (unit_res.is_count ? new_count : '0) : out_total_ff;
      out_last_in  = fire ? in_last_ff : out_last_ff;

      pred_acc_in  = pred_acc_ff;
      count_acc_in = count_acc_ff;
      if (fire) begin
         if (in_last_ff) begin
            pred_acc_in  = 1'b1;
            count_acc_in = '0;
         end else begin
            if (unit_res.is_pred) begin
               pred_acc_in = new_pred;
            end
            if (unit_res.is_count) begin
               count_acc_in = new_count;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pred_acc_ff  <= 1'b1;
         count_acc_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         pred_acc_ff  <= pred_acc_in;
         count_acc_ff <= count_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      in_kind_ff   <= in_kind_in;
      in_a_ff      <= in_a_in;
      in_b_ff      <= in_b_in;
      in_last_ff   <= in_last_in;
      in_tail_ff   <= in_tail_in;
      out_word_ff  <= out_word_in;
      out_pred_ff  <= out_pred_in;
      out_total_ff <= out_total_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_word = out_word_ff;
   assign rsp_predicate   = out_pred_ff;
   assign rsp_diff_total  = out_total_ff;
   assign rsp_last_result = out_last_ff;

endmodule

/* hw/rtl/fvl_checker.sv */
// ----------------------------------------------------------------------------
// fvl_checker
// port-level checks on the result channel of the four-valued logic vector alu
// ----------------------------------------------------------------------------
module fvl_checker import fvl_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [WORD_W-1:0]   rsp_result_word,
   input  logic                rsp_predicate,
   input  logic [COUNT_W-1:0]  rsp_diff_total,
   input  logic                rsp_last_result
);

   // stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_word) &&
         $stable(rsp_predicate) && $stable(rsp_diff_total) &&
         $stable(rsp_last_result))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a count result carries nothing else
   a_count_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_diff_total != '0 |-> !rsp_predicate && rsp_result_word == '0)
      else $error("count result mixed with other outputs");

   a_pred_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_predicate |-> rsp_result_word == '0 && rsp_diff_total == '0)
      else $error("predicate result mixed with other outputs");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_diff_total <= COUNT_CAP)
      else $error("count above cap");

endmodule

bind four_valued_logic_vector_alu_top fvl_checker u_fvl_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result_word (rsp_result_word),
   .rsp_predicate   (rsp_predicate),
   .rsp_diff_total  (rsp_diff_total),
   .rsp_last_result (rsp_last_result)
);
